@@ hdl/iee_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, operator codes and helper functions of the expression evaluator.
package iee_pkg;

    localparam int OP_DEPTH  = 32;
    localparam int VAL_DEPTH = 64;
    localparam int OP_AW     = $clog2(OP_DEPTH);
    localparam int OP_CW     = $clog2(OP_DEPTH + 1);
    localparam int VAL_AW    = $clog2(VAL_DEPTH);
    localparam int VAL_CW    = $clog2(VAL_DEPTH + 1);
    localparam int VW        = 64;
    localparam int CW        = 8;
    localparam int SW        = 3;

    typedef logic [3:0] t_opc;

    localparam t_opc OPC_P    = 4'd0;
    localparam t_opc OPC_N    = 4'd1;
    localparam t_opc OPC_POW  = 4'd2;
    localparam t_opc OPC_MUL  = 4'd3;
    localparam t_opc OPC_DIV  = 4'd4;
    localparam t_opc OPC_MOD  = 4'd5;
    localparam t_opc OPC_ADD  = 4'd6;
    localparam t_opc OPC_SUB  = 4'd7;
    localparam t_opc OPC_SHL  = 4'd8;
    localparam t_opc OPC_SHR  = 4'd9;
    localparam t_opc OPC_LPAR = 4'd10;
    localparam t_opc OPC_NONE = 4'd15;

    localparam logic [SW-1:0] ST_OK       = 3'd0;
    localparam logic [SW-1:0] ST_LEFTOVER = 3'd1;
    localparam logic [SW-1:0] ST_DIVZERO  = 3'd2;
    localparam logic [SW-1:0] ST_CLOSE    = 3'd3;
    localparam logic [SW-1:0] ST_OPEN     = 3'd4;
    localparam logic [SW-1:0] ST_UNKNOWN  = 3'd5;
    localparam logic [SW-1:0] ST_OVERFLOW = 3'd6;
    localparam logic [SW-1:0] ST_MISSING  = 3'd7;

    localparam logic [CW-1:0] CH_0     = 8'h30;
    localparam logic [CW-1:0] CH_9     = 8'h39;
    localparam logic [CW-1:0] CH_SP    = 8'h20;
    localparam logic [CW-1:0] CH_TAB   = 8'h09;
    localparam logic [CW-1:0] CH_CR    = 8'h0D;
    localparam logic [CW-1:0] CH_RPAR  = 8'h29;

    function automatic t_opc op_code(input logic [CW-1:0] c);
        t_opc r;
        unique case (c)
            8'h70:   r = OPC_P;    // p
            8'h6E:   r = OPC_N;    // n
            8'h5E:   r = OPC_POW;  // ^
            8'h2A:   r = OPC_MUL;  // *
            8'h2F:   r = OPC_DIV;  // /
            8'h25:   r = OPC_MOD;  // %
            8'h2B:   r = OPC_ADD;  // +
            8'h2D:   r = OPC_SUB;  // -
            8'h3C:   r = OPC_SHL;  // <
            8'h3E:   r = OPC_SHR;  // >
            8'h28:   r = OPC_LPAR; // (
            default: r = OPC_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] prec_of(input t_opc c);
        logic [2:0] r;
        unique case (c)
            OPC_P, OPC_N:                r = 3'd4;
            OPC_POW:                     r = 3'd3;
            OPC_MUL, OPC_DIV, OPC_MOD:   r = 3'd2;
            OPC_ADD, OPC_SUB:            r = 3'd1;
            default:                     r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic left_assoc(input t_opc c);
        return (c >= OPC_MUL) && (c <= OPC_SHR);
    endfunction

endpackage

@@ hdl/iee_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters in and results out.
interface iee_in_if;
    logic                      valid;
    logic                      ready;
    logic [iee_pkg::CW-1:0]    char_code;
    logic                      last;
    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface iee_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [iee_pkg::VW-1:0] value;
    logic [iee_pkg::SW-1:0]    status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hdl/iee_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/infix_expression_evaluator_top.sv @@
`timescale 1ns / 1ps
// Top level of the infix expression evaluator: sequencer, arithmetic units, stack RAMs.
//
//  channel   dir  payload                      request
//  i_in      in   char_code[7:0], last         one character of the expression
//  o_out     out  value[63:0] signed, status   one result per character with last
//
//  Multiply works on 64x16 partial products, one per cycle, and divide/remainder
//  gives one quotient bit per cycle; power squares and multiplies per exponent
//  bit. Both stacks sit in single-port-read RAMs, so the operands of an operator
//  are fetched one at a time.
//  Reset: synchronous, active low; clears counts and flags, stack RAMs are not swept.
//  Stalls: the result sits in an output register, so the next expression is taken
//  while it waits; only a second result waits for the first to be taken.
module infix_expression_evaluator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FLUSH = 4'd1;
    localparam logic [3:0] S_TOPRD = 4'd2;
    localparam logic [3:0] S_TOPW  = 4'd3;
    localparam logic [3:0] S_APPLY = 4'd4;
    localparam logic [3:0] S_VB    = 4'd5;
    localparam logic [3:0] S_VA    = 4'd6;
    localparam logic [3:0] S_EXEC  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_PW    = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_DIVF  = 4'd11;
    localparam logic [3:0] S_WB    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_OUTRD = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // what the pop loop is working for
    localparam logic [1:0] M_CLOSE = 2'd0;
    localparam logic [1:0] M_OPER  = 2'd1;
    localparam logic [1:0] M_FIN   = 2'd2;

    // where a multiply result goes
    localparam logic [1:0] D_RES = 2'd0;
    localparam logic [1:0] D_PR  = 2'd1;
    localparam logic [1:0] D_PB  = 2'd2;

    localparam int VW = iee_pkg::VW;

    logic [3:0]                  r_st;
    logic [1:0]                  r_mode;
    logic [iee_pkg::CW-1:0]      r_chr;
    logic                        r_last;
    logic [iee_pkg::OP_CW-1:0]   r_ocnt;
    logic [iee_pkg::VAL_CW-1:0]  r_vcnt;
    logic [VW-1:0]               r_acc;
    logic                        r_innum;
    logic                        r_lwo;
    logic                        r_any;
    logic [iee_pkg::SW-1:0]      r_err;
    iee_pkg::t_opc               r_code;   // operator waiting to be pushed
    iee_pkg::t_opc               r_opc;    // operator being applied
    logic [VW-1:0]               r_a, r_b, r_res;
    logic [VW-1:0]               r_mx, r_my, r_mp;
    logic [1:0]                  r_mcnt, r_mdst;
    logic [VW-1:0]               r_pr, r_pb, r_pe;
    logic [VW-1:0]               r_dq, r_dv, r_rem;
    logic [5:0]                  r_dcnt;
    logic                        r_qneg, r_rneg;
    logic                        r_ovalid;
    logic signed [VW-1:0]        r_oval;
    logic [iee_pkg::SW-1:0]      r_ostat;

    // stack RAM ports
    logic                        op_we;
    logic [iee_pkg::OP_AW-1:0]   op_waddr, op_raddr;
    iee_pkg::t_opc               op_wdata, op_rdata;
    logic                        val_we;
    logic [iee_pkg::VAL_AW-1:0]  val_waddr, val_raddr;
    logic [VW-1:0]               val_wdata, val_rdata;

    logic [iee_pkg::OP_CW-1:0]   ocnt_m1;
    logic [iee_pkg::VAL_CW-1:0]  vcnt_m1, vcnt_m2;
    logic                        is_digit, is_space;
    iee_pkg::t_opc               ch_code, un_code;
    logic                        fl_any, fl_lwo;
    logic [79:0]                 pp;
    logic [VW-1:0]               dt;
    logic                        dge;
    logic [VW-1:0]               un_res;
    logic                        pops;

    assign ocnt_m1   = r_ocnt - iee_pkg::OP_CW'(1);
    assign vcnt_m1   = r_vcnt - iee_pkg::VAL_CW'(1);
    assign vcnt_m2   = r_vcnt - iee_pkg::VAL_CW'(2);
    assign op_raddr  = ocnt_m1[iee_pkg::OP_AW-1:0];
    assign val_raddr = (r_st == S_VB) ? vcnt_m2[iee_pkg::VAL_AW-1:0]
                                      : vcnt_m1[iee_pkg::VAL_AW-1:0];

    assign is_digit = (r_chr >= iee_pkg::CH_0) && (r_chr <= iee_pkg::CH_9);
    assign is_space = (r_chr == iee_pkg::CH_SP) ||
                      ((r_chr >= iee_pkg::CH_TAB) && (r_chr <= iee_pkg::CH_CR));
    assign ch_code  = iee_pkg::op_code(r_chr);
    // flags as they stand once a pending literal has been pushed
    assign fl_any   = r_any | r_innum;
    assign fl_lwo   = r_innum ? 1'b0 : r_lwo;
    always_comb begin
        un_code = ch_code;
        if ((ch_code == iee_pkg::OPC_ADD || ch_code == iee_pkg::OPC_SUB) &&
            (!fl_any || fl_lwo)) begin
            un_code = (ch_code == iee_pkg::OPC_SUB) ? iee_pkg::OPC_N : iee_pkg::OPC_P;
        end
    end

    // pop the top while it binds tighter, or equally if the incoming one is left-assoc
    assign pops = (iee_pkg::prec_of(r_code) < iee_pkg::prec_of(op_rdata)) ||
                  ((iee_pkg::prec_of(r_code) == iee_pkg::prec_of(op_rdata)) &&
                   iee_pkg::left_assoc(r_code));

    assign pp  = r_mx * r_my[{r_mcnt, 4'd0} +: 16];
    assign dt  = {r_rem[VW-2:0], r_dq[VW-1]};
    assign dge = dt >= r_dv;

    always_comb begin
        if (r_opc == iee_pkg::OPC_P) begin
            un_res = r_b[VW-1] ? (VW'(0) - r_b) : r_b;
        end else begin
            un_res = (!r_b[VW-1] && r_b != '0) ? (VW'(0) - r_b) : r_b;
        end
    end

    // RAM writes: operator pushes and value pushes / write-backs
    always_comb begin
        op_we     = 1'b0;
        op_waddr  = r_ocnt[iee_pkg::OP_AW-1:0];
        op_wdata  = r_code;
        val_we    = 1'b0;
        val_waddr = r_vcnt[iee_pkg::VAL_AW-1:0];
        val_wdata = r_acc;
        unique case (r_st)
            S_FLUSH: begin
                val_we = r_innum && (r_vcnt < iee_pkg::VAL_CW'(iee_pkg::VAL_DEPTH));
                if (!(r_innum && !val_we) && r_err == iee_pkg::ST_OK && !is_space &&
                    ch_code == iee_pkg::OPC_LPAR &&
                    r_ocnt < iee_pkg::OP_CW'(iee_pkg::OP_DEPTH)) begin
                    op_we    = 1'b1;
                    op_wdata = iee_pkg::OPC_LPAR;
                end
            end
            S_TOPRD: begin
                op_we = (r_ocnt == '0) && (r_mode == M_OPER);
            end
            S_TOPW: begin
                op_we = (r_mode == M_OPER) &&
                        (op_rdata >= iee_pkg::OPC_LPAR || !pops) &&
                        (r_ocnt < iee_pkg::OP_CW'(iee_pkg::OP_DEPTH));
            end
            S_DONE: begin
                val_we = r_last && r_err == iee_pkg::ST_OK && r_mode != M_FIN && r_innum &&
                         (r_vcnt < iee_pkg::VAL_CW'(iee_pkg::VAL_DEPTH));
            end
            S_WB: begin
                val_we    = 1'b1;
                val_wdata = r_res;
                val_waddr = (r_opc <= iee_pkg::OPC_N) ? vcnt_m1[iee_pkg::VAL_AW-1:0]
                                                      : vcnt_m2[iee_pkg::VAL_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    iee_ram #(.WIDTH(4), .DEPTH(iee_pkg::OP_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (op_waddr),
        .i_wdata (op_wdata),
        .i_raddr (op_raddr),
        .o_rdata (op_rdata)
    );

    iee_ram #(.WIDTH(VW), .DEPTH(iee_pkg::VAL_DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    assign i_in.ready   = (r_st == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.value  = r_oval;
    assign o_out.status = r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_mode   <= M_CLOSE;
            r_ocnt   <= '0;
            r_vcnt   <= '0;
            r_acc    <= '0;
            r_innum  <= 1'b0;
            r_lwo    <= 1'b0;
            r_any    <= 1'b0;
            r_err    <= iee_pkg::ST_OK;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            // in S_OUT the result register is reloaded or left alone below
            if (o_out.ready && r_st != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_chr  <= i_in.char_code;
                        r_last <= i_in.last;
                        r_mode <= M_CLOSE;
                        if (r_err != iee_pkg::ST_OK) begin
                            r_st <= S_DONE;
                        end else if (i_in.char_code >= iee_pkg::CH_0 &&
                                     i_in.char_code <= iee_pkg::CH_9) begin
                            r_acc   <= (r_acc << 3) + (r_acc << 1) +
                                       VW'(i_in.char_code - iee_pkg::CH_0);
                            r_innum <= 1'b1;
                            r_st    <= S_DONE;
                        end else begin
                            r_st <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_innum) begin
                        r_acc   <= '0;
                        r_innum <= 1'b0;
                        r_lwo   <= 1'b0;
                        r_any   <= 1'b1;
                    end
                    if (r_innum && !val_we) begin
                        r_err <= iee_pkg::ST_OVERFLOW;
                        r_st  <= S_DONE;
                    end else begin
                        if (val_we) begin
                            r_vcnt <= r_vcnt + iee_pkg::VAL_CW'(1);
                        end
                        if (is_space) begin
                            r_st <= S_DONE;
                        end else if (r_chr == iee_pkg::CH_RPAR) begin
                            r_mode <= M_CLOSE;
                            r_st   <= S_TOPRD;
                        end else if (ch_code == iee_pkg::OPC_NONE) begin
                            r_err <= iee_pkg::ST_UNKNOWN;
                            r_st  <= S_DONE;
                        end else if (ch_code == iee_pkg::OPC_LPAR) begin
                            r_st <= S_DONE;
                            if (op_we) begin
                                r_ocnt <= r_ocnt + iee_pkg::OP_CW'(1);
                            end else begin
                                r_err <= iee_pkg::ST_OVERFLOW;
                            end
                        end else begin
                            r_code <= un_code;
                            r_mode <= M_OPER;
                            r_st   <= S_TOPRD;
                        end
                    end
                end
                S_TOPRD: begin
                    if (r_ocnt == '0) begin
                        unique case (r_mode)
                            M_CLOSE: begin
                                r_err <= iee_pkg::ST_CLOSE;
                                r_st  <= S_DONE;
                            end
                            M_OPER: begin
                                r_ocnt <= r_ocnt + iee_pkg::OP_CW'(1);
                                r_lwo  <= 1'b1;
                                r_st   <= S_DONE;
                            end
                            default: begin
                                if (r_vcnt == '0) begin
                                    r_err <= iee_pkg::ST_MISSING;
                                    r_st  <= S_DONE;
                                end else begin
                                    r_st <= S_OUTRD;
                                end
                            end
                        endcase
                    end else begin
                        r_st <= S_TOPW;
                    end
                end
                S_TOPW: begin
                    r_opc <= op_rdata;
                    unique case (r_mode)
                        M_CLOSE: begin
                            r_ocnt <= ocnt_m1;
                            r_st   <= (op_rdata == iee_pkg::OPC_LPAR) ? S_DONE : S_APPLY;
                        end
                        M_OPER: begin
                            if (op_rdata >= iee_pkg::OPC_LPAR || !pops) begin
                                r_lwo <= 1'b1;
                                r_st  <= S_DONE;
                                if (op_we) begin
                                    r_ocnt <= r_ocnt + iee_pkg::OP_CW'(1);
                                end else begin
                                    r_err <= iee_pkg::ST_OVERFLOW;
                                end
                            end else begin
                                r_ocnt <= ocnt_m1;
                                r_st   <= S_APPLY;
                            end
                        end
                        default: begin
                            r_ocnt <= ocnt_m1;
                            if (op_rdata >= iee_pkg::OPC_LPAR) begin
                                r_err <= iee_pkg::ST_OPEN;
                                r_st  <= S_DONE;
                            end else begin
                                r_st <= S_APPLY;
                            end
                        end
                    endcase
                end
                S_APPLY: begin
                    if ((r_opc <= iee_pkg::OPC_N && r_vcnt < iee_pkg::VAL_CW'(1)) ||
                        (r_opc > iee_pkg::OPC_N && r_vcnt < iee_pkg::VAL_CW'(2))) begin
                        r_err <= iee_pkg::ST_MISSING;
                        r_st  <= S_DONE;
                    end else begin
                        r_st <= S_VB;
                    end
                end
                S_VB: begin
                    r_b  <= val_rdata;
                    r_st <= (r_opc <= iee_pkg::OPC_N) ? S_EXEC : S_VA;
                end
                S_VA: begin
                    r_a  <= val_rdata;
                    r_st <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_opc)
                        iee_pkg::OPC_P, iee_pkg::OPC_N: begin
                            r_res <= un_res;
                            r_st  <= S_WB;
                        end
                        iee_pkg::OPC_ADD: begin
                            r_res <= r_a + r_b;
                            r_st  <= S_WB;
                        end
                        iee_pkg::OPC_SUB: begin
                            r_res <= r_a - r_b;
                            r_st  <= S_WB;
                        end
                        iee_pkg::OPC_SHL: begin
                            r_res <= (|r_b[VW-1:6]) ? '0 : (r_a << r_b[5:0]);
                            r_st  <= S_WB;
                        end
                        iee_pkg::OPC_SHR: begin
                            r_res <= (|r_b[VW-1:6]) ? {VW{r_a[VW-1]}}
                                     : VW'($signed(r_a) >>> r_b[5:0]);
                            r_st  <= S_WB;
                        end
                        iee_pkg::OPC_MUL: begin
                            r_mx   <= r_a;
                            r_my   <= r_b;
                            r_mp   <= '0;
                            r_mcnt <= '0;
                            r_mdst <= D_RES;
                            r_st   <= S_MUL;
                        end
                        iee_pkg::OPC_POW: begin
                            if (r_b[VW-1]) begin
                                r_res <= '0;
                                r_st  <= S_WB;
                            end else begin
                                r_pr <= VW'(1);
                                r_pb <= r_a;
                                r_pe <= r_b;
                                r_st <= S_PW;
                            end
                        end
                        default: begin
                            if (r_b == '0) begin
                                r_err <= iee_pkg::ST_DIVZERO;
                                r_st  <= S_DONE;
                            end else if (&r_b) begin
                                r_res <= (r_opc == iee_pkg::OPC_DIV) ? (VW'(0) - r_a) : '0;
                                r_st  <= S_WB;
                            end else begin
                                r_dq   <= r_a[VW-1] ? (VW'(0) - r_a) : r_a;
                                r_dv   <= r_b[VW-1] ? (VW'(0) - r_b) : r_b;
                                r_rem  <= '0;
                                r_dcnt <= '0;
                                r_qneg <= r_a[VW-1] ^ r_b[VW-1];
                                r_rneg <= r_a[VW-1];
                                r_st   <= S_DIV;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    // one 64x16 partial product per cycle, low 64 bits kept
                    r_mp   <= r_mp + (pp[VW-1:0] << {r_mcnt, 4'd0});
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        unique case (r_mdst)
                            D_PR: begin
                                r_pr    <= r_mp + (pp[VW-1:0] << {r_mcnt, 4'd0});
                                r_pe[0] <= 1'b0;
                                r_st    <= S_PW;
                            end
                            D_PB: begin
                                r_pb <= r_mp + (pp[VW-1:0] << {r_mcnt, 4'd0});
                                r_pe <= r_pe >> 1;
                                r_st <= S_PW;
                            end
                            default: begin
                                r_res <= r_mp + (pp[VW-1:0] << {r_mcnt, 4'd0});
                                r_st  <= S_WB;
                            end
                        endcase
                    end
                end
                S_PW: begin
                    // square and multiply, low exponent bit first
                    r_mp   <= '0;
                    r_mcnt <= '0;
                    if (r_pe == '0) begin
                        r_res <= r_pr;
                        r_st  <= S_WB;
                    end else if (r_pe[0]) begin
                        r_mx   <= r_pr;
                        r_my   <= r_pb;
                        r_mdst <= D_PR;
                        r_st   <= S_MUL;
                    end else begin
                        r_mx   <= r_pb;
                        r_my   <= r_pb;
                        r_mdst <= D_PB;
                        r_st   <= S_MUL;
                    end
                end
                S_DIV: begin
                    // restoring divide on magnitudes, one quotient bit per cycle
                    r_rem  <= dge ? (dt - r_dv) : dt;
                    r_dq   <= {r_dq[VW-2:0], dge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_st <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    if (r_opc == iee_pkg::OPC_DIV) begin
                        r_res <= r_qneg ? (VW'(0) - r_dq) : r_dq;
                    end else begin
                        r_res <= r_rneg ? (VW'(0) - r_rem) : r_rem;
                    end
                    r_st <= S_WB;
                end
                S_WB: begin
                    r_any <= 1'b1;
                    if (r_opc > iee_pkg::OPC_N) begin
                        r_vcnt <= vcnt_m1;
                    end
                    r_st <= S_TOPRD;
                end
                S_DONE: begin
                    if (!r_last) begin
                        r_st <= S_IDLE;
                    end else if (r_err != iee_pkg::ST_OK || r_mode == M_FIN) begin
                        r_st <= S_OUT;
                    end else begin
                        // end of expression: push a pending literal, then unwind
                        r_mode <= M_FIN;
                        if (r_innum) begin
                            r_acc   <= '0;
                            r_innum <= 1'b0;
                            r_lwo   <= 1'b0;
                            r_any   <= 1'b1;
                            if (val_we) begin
                                r_vcnt <= r_vcnt + iee_pkg::VAL_CW'(1);
                                r_st   <= S_TOPRD;
                            end else begin
                                r_err <= iee_pkg::ST_OVERFLOW;
                                r_st  <= S_DONE;
                            end
                        end else begin
                            r_st <= S_TOPRD;
                        end
                    end
                end
                S_OUTRD: begin
                    r_res <= val_rdata;
                    r_st  <= S_OUT;
                end
                default: begin
                    // S_OUT: load the result register once it is free
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        if (r_err != iee_pkg::ST_OK) begin
                            r_oval  <= '0;
                            r_ostat <= r_err;
                        end else begin
                            r_oval  <= r_res;
                            r_ostat <= (r_vcnt > iee_pkg::VAL_CW'(1)) ? iee_pkg::ST_LEFTOVER
                                                                      : iee_pkg::ST_OK;
                        end
                        r_ocnt  <= '0;
                        r_vcnt  <= '0;
                        r_acc   <= '0;
                        r_innum <= 1'b0;
                        r_lwo   <= 1'b0;
                        r_any   <= 1'b0;
                        r_err   <= iee_pkg::ST_OK;
                        r_last  <= 1'b0;
                        r_st    <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
